@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file of the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge while reset is released.
`define APST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define APST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/apst_pkg.sv @@
// Types and constants of the anemometer pulse speed tracker.
package apst_pkg;

  localparam int CapW    = 16;
  localparam int ScaleW  = 32;
  localparam int CfgW    = 32;
  localparam int CfgIdxW = 2;
  localparam int SpeedW  = 20;
  localparam int KmhW    = 21;
  localparam int ForceW  = 4;
  localparam int SumW    = 32;
  localparam int CountW  = 16;

  // Bit-serial divider: dividend and divisor widths.
  localparam int DvdW = 32;
  localparam int DvsW = 16;

  localparam logic [SpeedW-1:0] SpeedMax = '1;
  localparam logic [10:0]       KmhNum   = 11'd1609;
  localparam logic [9:0]        Milli    = 10'd1000;

  localparam logic [ScaleW-1:0] ScaleRst = 32'd29845968;
  localparam logic [CapW-1:0]   WrapRst  = 16'd65535;
  localparam logic [CapW-1:0]   CalmRst  = 16'd300;

  localparam int NumForce = 12;

  // Lowest speed in milli-mph of forces 1 to 12 (whole mph bounds times 1000).
  localparam logic [SpeedW-1:0] ForceStart [NumForce] = '{
    20'd1000,  20'd4000,  20'd8000,  20'd13000, 20'd18000, 20'd25000,
    20'd31000, 20'd39000, 20'd47000, 20'd55000, 20'd64000, 20'd74000
  };

  typedef enum logic [CfgIdxW-1:0] {
    RegSpeedScale    = 2'd0,
    RegWrapTop       = 2'd1,
    RegCalmThreshold = 2'd2
  } apst_reg_e;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } apst_div_req_t;

  // Beaufort force: count the force bounds the speed has reached.
  function automatic logic [ForceW-1:0] beaufort(input logic [SpeedW-1:0] speed);
    logic [ForceW-1:0] f;
    f = '0;
    for (int i = 0; i < NumForce; i++) begin
      if (speed >= ForceStart[i]) begin
        f = f + 1'b1;
      end
    end
    return f;
  endfunction

endpackage

@@ rtl/core/apst_cfg_if.sv @@
// Configuration write channel of the speed tracker.
interface apst_cfg_if;
  import apst_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] reg_index;
  logic [CfgW-1:0]    wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ rtl/core/apst_cap_if.sv @@
// Capture input channel of the speed tracker.
interface apst_cap_if;
  import apst_pkg::*;

  logic            valid;
  logic            ready;
  logic [CapW-1:0] capture;

  modport source (output valid, capture, input ready);
  modport sink   (input valid, capture, output ready);
endinterface

@@ rtl/core/apst_res_if.sv @@
// Result output channel of the speed tracker.
interface apst_res_if;
  import apst_pkg::*;

  logic              valid;
  logic              ready;
  logic [SpeedW-1:0] speed_mmph;
  logic [KmhW-1:0]   speed_mkmh;
  logic [SpeedW-1:0] min_mmph;
  logic [SpeedW-1:0] max_mmph;
  logic [ForceW-1:0] force_res;
  logic              record_valid;
  logic [SpeedW-1:0] average_mmph;

  modport source (output valid, speed_mmph, speed_mkmh, min_mmph, max_mmph, force_res,
                  record_valid, average_mmph, input ready);
  modport sink   (input valid, speed_mmph, speed_mkmh, min_mmph, max_mmph, force_res,
                  record_valid, average_mmph, output ready);
endinterface

@@ rtl/core/apst_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module apst_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  apst_pkg::apst_div_req_t     req_i,
  output logic                        busy_o,
  output logic [apst_pkg::DvdW-1:0]   quotient_o
);
  import apst_pkg::*;

  localparam int CntW = $clog2(DvdW);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [DvdW-1:0] dvd_q;
  logic [DvsW-1:0] dvs_q;
  logic [DvsW:0]   rem_q;
  logic [DvsW:0]   rem_shift;
  logic [DvsW:0]   rem_sub;
  logic            ge;

  // Shift in the next dividend bit and try the subtraction.
  assign rem_shift = {rem_q[DvsW-1:0], dvd_q[DvdW-1]};
  assign ge        = rem_shift >= {1'b0, dvs_q};
  assign rem_sub   = rem_shift - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      dvd_q  <= req_i.dividend;
      dvs_q  <= req_i.divisor;
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub : rem_shift;
      // Dividend bits leave at the top, quotient bits enter at the bottom.
      dvd_q <= {dvd_q[DvdW-2:0], ge};
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(DvdW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = dvd_q;

endmodule

@@ rtl/core/anemometer_pulse_speed_tracker_core.sv @@
// Anemometer speed tracker: one capture in, speed, extremes, force and window average out.
// Each capture transaction holds the timer count of one anemometer pulse. The first
// capture after reset is stored and gives no result, and the block stays ready for the
// next capture. Every later capture gives exactly one result. That result is loaded after
// these steps in order: the speed quotient, the update step, the classify step, the km/h
// and window-average quotients that run side by side (the average only when the force
// changes), and the load of the output register. The block returns to idle with the load
// and then accepts the next capture. When the period is zero the speed quotient is
// skipped. The quotients come from bit-serial dividers, one quotient bit per cycle. The
// result may still wait on the output while the next capture is processed. A stalled
// output holds the next result back in the finish state, and no capture is taken until
// that result is loaded. Configuration writes are always ready.
module anemometer_pulse_speed_tracker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  apst_cfg_if.sink    cfg_i,
  apst_cap_if.sink    cap_i,
  apst_res_if.source  res_o
);
  import apst_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StDivSpeed,
    StApply,
    StClassify,
    StDivOut,
    StFinish
  } state_e;

  // Configuration registers.
  logic [ScaleW-1:0] scale_q;
  logic [CapW-1:0]   wrap_q;
  logic [CapW-1:0]   calm_q;

  state_e            state_q;
  logic              have_first_q;
  logic [CapW-1:0]   prev_q;
  logic              seeded_q;
  logic [SpeedW-1:0] min_q;
  logic [SpeedW-1:0] max_q;
  logic [SumW-1:0]   sum_q;
  logic [CountW-1:0] count_q;
  logic [ForceW-1:0] last_force_q;
  logic [SpeedW-1:0] speed_raw_q;
  logic [SpeedW-1:0] speed_q;
  logic [ForceW-1:0] force_q;
  logic              rec_q;

  logic              out_valid_q;
  logic [SpeedW-1:0] out_speed_q;
  logic [KmhW-1:0]   out_kmh_q;
  logic [SpeedW-1:0] out_min_q;
  logic [SpeedW-1:0] out_max_q;
  logic [ForceW-1:0] out_force_q;
  logic              out_rec_q;
  logic [SpeedW-1:0] out_avg_q;

  logic              cap_accept;
  logic [CapW-1:0]   gap;
  logic [CapW-1:0]   period;
  logic [SpeedW-1:0] speed_q_sat;
  logic [SpeedW-1:0] min_seed;
  logic [SpeedW-1:0] max_seed;
  logic [SpeedW-1:0] speed_calm;
  logic [SumW:0]     sum_add;
  logic [ForceW-1:0] force_new;
  logic              force_chg;
  logic [DvdW-1:0]   kmh_prod;
  logic              out_free;

  apst_div_req_t     spd_req, kmh_req, avg_req;
  logic              spd_busy, kmh_busy, avg_busy;
  logic [DvdW-1:0]   spd_quot, kmh_quot, avg_quot;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleRst;
      wrap_q  <= WrapRst;
      calm_q  <= CalmRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        RegSpeedScale:    scale_q <= cfg_i.wdata;
        RegWrapTop:       wrap_q  <= cfg_i.wdata[CapW-1:0];
        RegCalmThreshold: calm_q  <= cfg_i.wdata[CapW-1:0];
        default: ;
      endcase
    end
  end

  assign cap_i.ready = (state_q == StIdle);
  assign cap_accept  = cap_i.valid && cap_i.ready;

  // Period with wrap through the reload value; a gap the reload cannot cover gives zero.
  assign gap    = prev_q - cap_i.capture;
  always_comb begin
    if (cap_i.capture >= prev_q) begin
      period = cap_i.capture - prev_q;
    end else if (wrap_q > gap) begin
      period = wrap_q - gap;
    end else begin
      period = '0;
    end
  end

  assign spd_req.start    = cap_accept && have_first_q && (period != '0);
  assign spd_req.dividend = scale_q;
  assign spd_req.divisor  = period;

  assign speed_q_sat = (spd_quot > DvdW'(SpeedMax)) ? SpeedMax : spd_quot[SpeedW-1:0];

  // Extremes are seeded with the speed before the calm test.
  assign min_seed   = seeded_q ? min_q : speed_raw_q;
  assign max_seed   = seeded_q ? max_q : speed_raw_q;
  assign speed_calm = (speed_raw_q <= {{(SpeedW-CapW){1'b0}}, calm_q}) ? '0 : speed_raw_q;
  assign sum_add    = {1'b0, sum_q} + (SumW+1)'(speed_calm);

  assign force_new = beaufort(speed_q);
  assign force_chg = (force_new != last_force_q);
  assign kmh_prod  = DvdW'(speed_q) * DvdW'(KmhNum);

  assign kmh_req.start    = (state_q == StClassify);
  assign kmh_req.dividend = kmh_prod;
  assign kmh_req.divisor  = DvsW'(Milli);

  assign avg_req.start    = (state_q == StClassify) && force_chg;
  assign avg_req.dividend = sum_q;
  assign avg_req.divisor  = count_q;

  assign out_free = !out_valid_q || res_o.ready;

  apst_div u_spd_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (spd_req),
    .busy_o     (spd_busy),
    .quotient_o (spd_quot)
  );

  apst_div u_kmh_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (kmh_req),
    .busy_o     (kmh_busy),
    .quotient_o (kmh_quot)
  );

  apst_div u_avg_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (avg_req),
    .busy_o     (avg_busy),
    .quotient_o (avg_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      have_first_q <= 1'b0;
      prev_q       <= '0;
      seeded_q     <= 1'b0;
      min_q        <= '0;
      max_q        <= '0;
      sum_q        <= '0;
      count_q      <= '0;
      last_force_q <= '0;
      speed_raw_q  <= '0;
      speed_q      <= '0;
      force_q      <= '0;
      rec_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_speed_q  <= '0;
      out_kmh_q    <= '0;
      out_min_q    <= '0;
      out_max_q    <= '0;
      out_force_q  <= '0;
      out_rec_q    <= 1'b0;
      out_avg_q    <= '0;
    end else begin
      // Load a new result transaction, or drop the one taken by the sink.
      if ((state_q == StFinish) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (cap_accept) begin
            prev_q       <= cap_i.capture;
            have_first_q <= 1'b1;
            if (have_first_q) begin
              if (period == '0) begin
                speed_raw_q <= SpeedMax;
                state_q     <= StApply;
              end else begin
                state_q <= StDivSpeed;
              end
            end
          end
        end
        StDivSpeed: begin
          if (!spd_busy) begin
            speed_raw_q <= speed_q_sat;
            state_q     <= StApply;
          end
        end
        StApply: begin
          speed_q  <= speed_calm;
          seeded_q <= 1'b1;
          if (speed_calm > max_seed) begin
            max_q <= speed_calm;
            min_q <= min_seed;
          end else if ((speed_calm != '0) && (speed_calm < min_seed)) begin
            max_q <= max_seed;
            min_q <= speed_calm;
          end else begin
            max_q <= max_seed;
            min_q <= min_seed;
          end
          sum_q <= sum_add[SumW] ? '1 : sum_add[SumW-1:0];
          if (count_q != '1) begin
            count_q <= count_q + 1'b1;
          end
          state_q <= StClassify;
        end
        StClassify: begin
          force_q <= force_new;
          rec_q   <= force_chg;
          // Restart the window once its sum and count are handed to the divider.
          if (force_chg) begin
            last_force_q <= force_new;
            sum_q        <= '0;
            count_q      <= '0;
          end
          state_q <= StDivOut;
        end
        StDivOut: begin
          if (!kmh_busy && !avg_busy) begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (out_free) begin
            out_speed_q <= speed_q;
            out_kmh_q   <= kmh_quot[KmhW-1:0];
            out_min_q   <= min_q;
            out_max_q   <= max_q;
            out_force_q <= force_q;
            out_rec_q   <= rec_q;
            if (!rec_q) begin
              out_avg_q <= '0;
            end else if (avg_quot > DvdW'(SpeedMax)) begin
              out_avg_q <= SpeedMax;
            end else begin
              out_avg_q <= avg_quot[SpeedW-1:0];
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.speed_mmph   = out_speed_q;
  assign res_o.speed_mkmh   = out_kmh_q;
  assign res_o.min_mmph     = out_min_q;
  assign res_o.max_mmph     = out_max_q;
  assign res_o.force_res    = out_force_q;
  assign res_o.record_valid = out_rec_q;
  assign res_o.average_mmph = out_avg_q;

endmodule

@@ rtl/core/apst_checker.sv @@
// Port-level checker of the speed tracker and its bind to the top level.
`include "assert_macros.svh"

module apst_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [apst_pkg::SpeedW-1:0]   res_speed_i,
  input logic [apst_pkg::KmhW-1:0]     res_kmh_i,
  input logic [apst_pkg::SpeedW-1:0]   res_min_i,
  input logic [apst_pkg::SpeedW-1:0]   res_max_i,
  input logic [apst_pkg::ForceW-1:0]   res_force_i,
  input logic                          res_rec_i,
  input logic [apst_pkg::SpeedW-1:0]   res_avg_i
);
  import apst_pkg::*;

  logic [SpeedW*4+KmhW+ForceW:0] res_pack;
  logic                          speed_in_range;
  logic                          calm_quiet;

  assign res_pack = {res_speed_i, res_kmh_i, res_min_i, res_max_i, res_force_i, res_rec_i,
                     res_avg_i};

  // Extremes bracket the current speed; zero never lowers the minimum.
  assign speed_in_range = (res_speed_i <= res_max_i) &&
                          ((res_speed_i == '0) || (res_min_i <= res_speed_i));
  assign calm_quiet     = (res_kmh_i == '0) && (res_force_i == '0);

  // Hold a stalled result transaction.
  `APST_ASSERT(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_pack), "result changed while stalled")

  `APST_ASSERT(a_avg_quiet, res_valid_i && !res_rec_i |-> res_avg_i == '0, "average without record")

  `APST_ASSERT(a_extremes, res_valid_i |-> speed_in_range, "speed outside extremes")

  `APST_ASSERT(a_calm, res_valid_i && (res_speed_i == '0) |-> calm_quiet, "calm speed not quiet")

  `APST_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !res_valid_i, "result during reset")

endmodule

bind anemometer_pulse_speed_tracker_core apst_checker u_apst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_speed_i (res_o.speed_mmph),
  .res_kmh_i   (res_o.speed_mkmh),
  .res_min_i   (res_o.min_mmph),
  .res_max_i   (res_o.max_mmph),
  .res_force_i (res_o.force_res),
  .res_rec_i   (res_o.record_valid),
  .res_avg_i   (res_o.average_mmph)
);

@@ test/tb.sv @@
// Testbench for the anemometer speed tracker: drives captures, predicts and checks each result.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import apst_pkg::*;

  typedef struct packed {
    logic [SpeedW-1:0] speed_mmph;
    logic [KmhW-1:0]   speed_mkmh;
    logic [SpeedW-1:0] min_mmph;
    logic [SpeedW-1:0] max_mmph;
    logic [ForceW-1:0] force_res;
    logic              record_valid;
    logic [SpeedW-1:0] average_mmph;
  } wind_result_t;

  localparam int unsigned BeaufortTopMph [12] = '{0, 3, 7, 12, 17, 24, 30, 38, 46, 54, 63, 73};
  localparam int unsigned SpeedSat = 1048575;

  logic clk_i = 1'b0;
  logic rst_ni;

  apst_cfg_if cfg_bus ();
  apst_cap_if cap_bus ();
  apst_res_if res_bus ();

  anemometer_pulse_speed_tracker_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .cap_i  (cap_bus),
    .res_o  (res_bus)
  );

  always #4 clk_i = ~clk_i;

  // Register copies and tracker state of the predictor.
  int unsigned scale_cfg = ScaleRst;
  int unsigned wrap_cfg  = 32'(WrapRst);
  int unsigned calm_cfg  = 32'(CalmRst);
  logic        seen_first      = 1'b0;
  logic        extremes_loaded = 1'b0;
  int unsigned last_cap     = 0;
  int unsigned speed_min    = 0;
  int unsigned speed_max    = 0;
  int unsigned window_sum   = 0;
  int unsigned window_count = 0;
  int unsigned force_now    = 0;

  logic [CapW-1:0] pending_captures [$];
  wind_result_t    expected_results [$];
  int unsigned     timer_pos = 0;

  int          error_count  = 0;
  int unsigned idle_left    = 0;
  int unsigned stall_left   = 0;
  int unsigned results_seen = 0;
  logic        hold_done    = 1'b0;

  function automatic int unsigned beaufort_force(input int unsigned mph);
    for (int f = 0; f < 12; f++) begin
      if (mph <= BeaufortTopMph[f]) return f;
    end
    return 12;
  endfunction

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned draw_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic track_pulse(input logic [CapW-1:0] cap);
    int unsigned now_cap, gap, period, spd, lvl, avg;
    wind_result_t r;
    now_cap = 32'(cap);
    if (!seen_first) begin
      last_cap   = now_cap;
      seen_first = 1'b1;
      return;
    end
    if (now_cap >= last_cap) begin
      period = now_cap - last_cap;
    end else begin
      gap    = last_cap - now_cap;
      period = (wrap_cfg > gap) ? wrap_cfg - gap : 0;
    end
    last_cap = now_cap;

    if (period == 0) begin
      spd = SpeedSat;
    end else begin
      spd = scale_cfg / period;
      if (spd > SpeedSat) spd = SpeedSat;
    end
    // Seed the extremes before the calm cut.
    if (!extremes_loaded) begin
      speed_min       = spd;
      speed_max       = spd;
      extremes_loaded = 1'b1;
    end
    if (spd <= calm_cfg) spd = 0;
    if (spd > speed_max) speed_max = spd;
    else if (spd != 0 && spd < speed_min) speed_min = spd;

    window_sum = (window_sum > 32'hFFFF_FFFF - spd) ? 32'hFFFF_FFFF : window_sum + spd;
    if (window_count < 16'hFFFF) window_count++;

    lvl = beaufort_force(spd / 1000);
    r.record_valid = 1'b0;
    avg = 0;
    if (lvl != force_now) begin
      force_now      = lvl;
      r.record_valid = 1'b1;
      avg = (window_count != 0) ? window_sum / window_count : 0;
      if (avg > SpeedSat) avg = SpeedSat;
      window_sum   = 0;
      window_count = 0;
    end
    r.speed_mmph   = SpeedW'(spd);
    r.speed_mkmh   = KmhW'((spd * 1609) / 1000);
    r.min_mmph     = SpeedW'(speed_min);
    r.max_mmph     = SpeedW'(speed_max);
    r.force_res    = ForceW'(lvl);
    r.average_mmph = SpeedW'(avg);
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Capture driver: take transactions from the pending queue, with random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cap_bus.valid <= 1'b0;
      idle_left     <= 0;
    end else begin
      if (cap_bus.valid && cap_bus.ready) track_pulse(cap_bus.capture);
      if (!(cap_bus.valid && !cap_bus.ready)) begin
        if (idle_left != 0) begin
          idle_left     <= idle_left - 1;
          cap_bus.valid <= 1'b0;
        end else if (pending_captures.size() != 0) begin
          cap_bus.valid   <= 1'b1;
          cap_bus.capture <= pending_captures.pop_front();
          idle_left       <= draw_idle();
        end else begin
          cap_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin : result_check
    wind_result_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        report_mismatch("result with none expected");
      end else begin
        want = expected_results.pop_front();
        check_field("speed_mmph", 32'(res_bus.speed_mmph), 32'(want.speed_mmph));
        check_field("speed_mkmh", 32'(res_bus.speed_mkmh), 32'(want.speed_mkmh));
        check_field("min_mmph", 32'(res_bus.min_mmph), 32'(want.min_mmph));
        check_field("max_mmph", 32'(res_bus.max_mmph), 32'(want.max_mmph));
        check_field("force_res", 32'(res_bus.force_res), 32'(want.force_res));
        check_field("record_valid", 32'(res_bus.record_valid), 32'(want.record_valid));
        check_field("average_mmph", 32'(res_bus.average_mmph), 32'(want.average_mmph));
      end
    end
  end

  // Result ready: random stalls, plus one long hold-off to back the block up.
  always @(posedge clk_i) begin : result_ready
    int unsigned n;
    if (rst_ni) begin
      if (!hold_done && results_seen >= 250) begin
        hold_done     <= 1'b1;
        stall_left    <= 900;
        res_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        res_bus.ready <= 1'b0;
      end else begin
        n = ($urandom_range(0, 3) == 0) ? draw_idle() : 0;
        if (n != 0) begin
          stall_left    <= n - 1;
          res_bus.ready <= 1'b0;
        end else begin
          res_bus.ready <= 1'b1;
        end
      end
    end
  end

  task automatic write_reg(input apst_reg_e idx, input logic [CfgW-1:0] data);
    @(posedge clk_i);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wdata     <= data;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cfg_bus.valid <= 1'b0;
    case (idx)
      RegSpeedScale:    scale_cfg = data;
      RegWrapTop:       wrap_cfg  = 32'(data[CapW-1:0]);
      RegCalmThreshold: calm_cfg  = 32'(data[CapW-1:0]);
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [CfgW-1:0] scale, input logic [CfgW-1:0] wrap,
                          input logic [CfgW-1:0] calm);
    write_reg(RegSpeedScale, scale);
    write_reg(RegWrapTop, wrap);
    write_reg(RegCalmThreshold, calm);
  endtask

  task automatic capture_push(input int unsigned v);
    pending_captures.push_back(CapW'(v));
    timer_pos = v & 16'hFFFF;
  endtask

  // Next capture one period on, wrapping through the reload value as the timer would.
  task automatic queue_period(input int unsigned p);
    int unsigned nxt;
    nxt = timer_pos + p;
    if (p < wrap_cfg && nxt >= wrap_cfg) nxt = nxt - wrap_cfg;
    capture_push(nxt);
  endtask

  function automatic int unsigned speed_in_band(input int unsigned band);
    int unsigned lo, hi;
    lo = (band == 0) ? 1 : (BeaufortTopMph[band-1] + 1) * 1000;
    hi = (band == 12) ? 120000 : BeaufortTopMph[band] * 1000 + 999;
    return $urandom_range(lo, hi);
  endfunction

  function automatic int unsigned period_for(input int unsigned spd);
    int unsigned p;
    p = scale_cfg / spd;
    if (p == 0) p = 1;
    if (p > 65535) p = 65535;
    return p;
  endfunction

  // Runs of captures that dwell in one force band, with some noise and zero periods.
  task automatic queue_weather(input int n);
    int i;
    int unsigned target, spd, dwell;
    i = 0;
    while (i < n) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          capture_push($urandom_range(0, 65535));
          i++;
        end
        2: begin
          capture_push(timer_pos);
          i++;
        end
        default: begin
          target = speed_in_band($urandom_range(0, 12));
          dwell  = $urandom_range(1, 6);
          repeat (dwell) begin
            spd = target + $urandom_range(0, target / 16) - target / 32;
            if (spd == 0) spd = 1;
            queue_period(period_for(spd));
            i++;
          end
        end
      endcase
    end
  endtask

  // Hold until every capture is sent and every result is back, then let the block settle.
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_captures.size() != 0 || cap_bus.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.reg_index = RegSpeedScale;
    cfg_bus.wdata     = '0;
    cap_bus.valid     = 1'b0;
    cap_bus.capture   = '0;
    res_bus.ready     = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: first capture, zero period, longest period, wrap gap equal to the
    // reload value, alternating bit patterns, then one capture in each force band.
    capture_push(0);
    capture_push(0);
    capture_push(65535);
    capture_push(0);
    capture_push(16'h5555);
    capture_push(16'hAAAA);
    for (int b = 0; b <= 12; b++) queue_period(period_for(speed_in_band(b)));
    wait_drained();

    // Calm cut right at, just above and just below the threshold.
    set_regs(1000000, 65535, 1000);
    queue_period(1000);
    queue_period(999);
    queue_period(1001);
    queue_weather(40);
    wait_drained();

    set_regs(0, 1, 0);
    queue_weather(50);
    wait_drained();

    set_regs(32'hFFFF_FFFF, 65535, 65535);
    queue_weather(50);
    wait_drained();

    // Run of saturated speeds in one force band to grow the window sum.
    set_regs(ScaleRst, WrapRst, CalmRst);
    queue_period(200);
    repeat (30) capture_push(timer_pos);
    queue_period(29845);
    wait_drained();

    repeat (6) begin
      set_regs($urandom_range(2000000, 60000000),
               $urandom_range(0, 1) ? 65535 : $urandom_range(2000, 65535),
               $urandom_range(0, 1) ? $urandom_range(0, 1500) : $urandom_range(0, 65535));
      queue_weather(110);
      wait_drained();
    end

    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ anemometer_pulse_speed_tracker_core.f @@
+incdir+rtl/core
rtl/core/apst_pkg.sv
rtl/core/apst_cfg_if.sv
rtl/core/apst_cap_if.sv
rtl/core/apst_res_if.sv
rtl/core/apst_div.sv
rtl/core/anemometer_pulse_speed_tracker_core.sv
rtl/core/apst_checker.sv
test/tb.sv
